FILE: hdl/tpig_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpig_pkg
// Shared constants, register indexes, pad modes and the back-end state type
// of the tensor pad index generator.
// ----------------------------------------------------------------------------
package tpig_pkg;

  localparam int DEF_MAX_RANK = 4;
  localparam int DEF_DIM_BITS = 16;

  localparam int IDX_W     = 64;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int MODE_W    = 2;
  localparam int RANK_W    = 3;

  // entries in the queue between front and back, a power of two
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PAD_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TENSOR_RANK   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_SIZES   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEADING_PADS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRAILING_PADS = 3'd4;

  localparam logic [MODE_W-1:0] MODE_CONSTANT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EDGE     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REFLECT  = 2'd2;

  localparam logic [RANK_W-1:0] RANK_RESET = 3'd4;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_AXIS,
    BK_DIV,
    BK_REFL,
    BK_ACC,
    BK_OUT
  } back_state_t;

endpackage

FILE: hdl/tpig_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpig_front
// Holds the output coordinate, takes one item per cycle while the queue has
// room, flags the last element and advances the coordinate in row-major order.
// ----------------------------------------------------------------------------
module tpig_front #(
  parameter int MAX_RANK = tpig_pkg::DEF_MAX_RANK,
  parameter int DIM_BITS = tpig_pkg::DEF_DIM_BITS,
  localparam int CW  = DIM_BITS + 2,
  localparam int RCW = $clog2(MAX_RANK + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  logic                   restart,
  input  logic [RCW-1:0]         active_rank,
  input  logic [DIM_BITS-1:0]    sizes  [MAX_RANK],
  input  logic [DIM_BITS-1:0]    leads  [MAX_RANK],
  input  logic [DIM_BITS-1:0]    trails [MAX_RANK],
  output logic                   push_valid,
  input  logic                   push_ready,
  output logic [MAX_RANK*CW:0]   push_data
);

  logic [CW-1:0] coord      [MAX_RANK];
  logic [CW-1:0] coord_next [MAX_RANK];
  logic [CW-1:0] eff        [MAX_RANK];
  logic [CW-1:0] extent     [MAX_RANK];
  logic          last_flag;
  logic          carry;
  logic [CW:0]   bump;

  assign push_valid = item_valid;
  assign item_ready = push_ready;

  always_comb begin
    last_flag = 1'b1;
    carry     = 1'b1;
    bump      = '0;
    for (int a = 0; a < MAX_RANK; a++) begin
      extent[a] = CW'(sizes[a]) + CW'(leads[a]) + CW'(trails[a]);
      if (extent[a] == '0) begin
        extent[a] = CW'(1);
      end
      eff[a] = restart ? '0 : coord[a];
      if (a < int'(active_rank) && eff[a] != extent[a] - CW'(1)) begin
        last_flag = 1'b0;
      end
    end
    // innermost axis first, carry ripples outward; unused slots keep their value
    for (int a = MAX_RANK - 1; a >= 0; a--) begin
      coord_next[a] = eff[a];
      bump          = {1'b0, eff[a]} + (CW + 1)'(1);
      if (a < int'(active_rank) && carry) begin
        if (bump < {1'b0, extent[a]}) begin
          coord_next[a] = bump[CW-1:0];
          carry         = 1'b0;
        end else begin
          coord_next[a] = '0;
        end
      end
    end
    push_data[MAX_RANK*CW] = last_flag;
    for (int a = 0; a < MAX_RANK; a++) begin
      push_data[a*CW +: CW] = eff[a];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < MAX_RANK; a++) begin
        coord[a] <= '0;
      end
    end else if (item_valid && item_ready) begin
      coord <= coord_next;
    end
  end

endmodule

FILE: hdl/tpig_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpig_queue
// Small first-in first-out queue of classified items between the front and
// the back.
// ----------------------------------------------------------------------------
module tpig_queue #(
  parameter int W = tpig_pkg::DEF_DIM_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int PW   = $clog2(tpig_pkg::QUEUE_DEPTH);
  localparam int CNTW = $clog2(tpig_pkg::QUEUE_DEPTH + 1);

  logic [W-1:0]    entry [tpig_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = count != CNTW'(tpig_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers wrap on their own since the depth is a power of two
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNTW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: hdl/tpig_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpig_back
// Maps one queued coordinate to a source index, axis by axis, with a
// bit-serial remainder unit for reflect mode and a multiply-accumulate of
// the row-major index. Holds the result in an output register.
// ----------------------------------------------------------------------------
module tpig_back #(
  parameter int MAX_RANK = tpig_pkg::DEF_MAX_RANK,
  parameter int DIM_BITS = tpig_pkg::DEF_DIM_BITS,
  localparam int CW    = DIM_BITS + 2,
  localparam int RCW   = $clog2(MAX_RANK + 1),
  localparam int AXW   = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1,
  localparam int CNT_W = $clog2(CW)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [tpig_pkg::MODE_W-1:0] mode,
  input  logic [RCW-1:0]              active_rank,
  input  logic [DIM_BITS-1:0]         sizes [MAX_RANK],
  input  logic [DIM_BITS-1:0]         leads [MAX_RANK],
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  logic [MAX_RANK*CW:0]        pop_data,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [tpig_pkg::IDX_W-1:0]  source_index,
  output logic                        is_padding,
  output logic                        last
);

  localparam int HALF_W = tpig_pkg::IDX_W / 2;
  localparam int LO_W   = HALF_W + DIM_BITS;

  tpig_pkg::back_state_t state, state_next;

  logic [CW-1:0]              coord [MAX_RANK];
  logic                       last_q;
  logic [tpig_pkg::IDX_W-1:0] src;
  logic                       pad;
  logic [DIM_BITS-1:0]        s_val;
  logic [AXW-1:0]             ax;
  logic                       neg_q;
  logic [DIM_BITS:0]          rem;
  logic [CW-1:0]              dvd;
  logic [DIM_BITS:0]          modulus;
  logic [CNT_W-1:0]           cnt;
  logic [LO_W-1:0]            prod_lo;
  logic [HALF_W-1:0]          prod_hi;

  logic [CW-1:0]                       cur_c;
  logic [DIM_BITS-1:0]                 n;
  logic [CW:0]                         rel;
  logic [CW:0]                         neg_rel;
  logic                                neg;
  logic [CW-1:0]                       mag;
  logic                                above;
  logic [DIM_BITS:0]                   modulus_axis;
  logic [DIM_BITS-1:0]                 axis_s;
  logic                                axis_pad;
  logic                                need_div;
  logic [DIM_BITS+1:0]                 rtmp;
  logic [DIM_BITS+1:0]                 rsub;
  logic [DIM_BITS:0]                   rem_step;
  logic [DIM_BITS:0]                   q0;
  logic [DIM_BITS:0]                   q1;
  logic [LO_W-1:0]                     mul_lo;
  logic [HALF_W-1:0]                   mul_hi;
  logic [tpig_pkg::IDX_W-1:0]          acc;
  logic                                last_axis;
  logic                                out_free;

  // per-axis mapping
  always_comb begin
    cur_c        = coord[ax];
    n            = sizes[ax];
    rel          = {1'b0, cur_c} - (CW + 1)'(leads[ax]);
    neg_rel      = (CW + 1)'(0) - rel;
    neg          = rel[CW];
    mag          = neg ? neg_rel[CW-1:0] : rel[CW-1:0];
    above        = !neg && (rel[CW-1:0] >= CW'(n));
    modulus_axis = {n - DIM_BITS'(1), 1'b0};
    axis_s       = '0;
    axis_pad     = 1'b0;
    need_div     = 1'b0;
    if (n == '0) begin
      axis_pad = 1'b1;
    end else begin
      unique case (mode)
        tpig_pkg::MODE_EDGE: begin
          if (neg) begin
            axis_s = '0;
          end else if (above) begin
            axis_s = n - DIM_BITS'(1);
          end else begin
            axis_s = rel[DIM_BITS-1:0];
          end
        end
        tpig_pkg::MODE_REFLECT: begin
          // an axis of size one maps to zero
          need_div = n != DIM_BITS'(1);
        end
        default: begin
          if (neg || above) begin
            axis_pad = 1'b1;
          end else begin
            axis_s = rel[DIM_BITS-1:0];
          end
        end
      endcase
    end
  end

  // restoring remainder, one dividend bit per cycle, then fold the mirror
  always_comb begin
    rtmp     = {rem, dvd[CW-1]};
    rsub     = rtmp - {1'b0, modulus};
    rem_step = (rtmp >= {1'b0, modulus}) ? rsub[DIM_BITS:0] : rtmp[DIM_BITS:0];
    q0       = (neg_q && rem != '0) ? modulus - rem : rem;
    q1       = (q0 >= {1'b0, n}) ? modulus - q0 : q0;
  end

  // index times size in two halves, the upper half only needs its low bits
  assign mul_lo    = LO_W'(src[HALF_W-1:0]) * LO_W'(n);
  assign mul_hi    = src[tpig_pkg::IDX_W-1:HALF_W] * HALF_W'(n);
  assign acc       = tpig_pkg::IDX_W'(prod_lo) + {prod_hi, HALF_W'(0)}
                   + tpig_pkg::IDX_W'(s_val);
  assign last_axis = (RCW'(ax) + RCW'(1)) == active_rank;
  assign out_free  = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpig_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop_ready  = 1'b0;
    unique case (state)
      tpig_pkg::BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          state_next = tpig_pkg::BK_AXIS;
        end
      end
      tpig_pkg::BK_AXIS: begin
        state_next = need_div ? tpig_pkg::BK_DIV : tpig_pkg::BK_ACC;
      end
      tpig_pkg::BK_DIV: begin
        if (cnt == CNT_W'(CW - 1)) begin
          state_next = tpig_pkg::BK_REFL;
        end
      end
      tpig_pkg::BK_REFL: begin
        state_next = tpig_pkg::BK_ACC;
      end
      tpig_pkg::BK_ACC: begin
        state_next = last_axis ? tpig_pkg::BK_OUT : tpig_pkg::BK_AXIS;
      end
      tpig_pkg::BK_OUT: begin
        if (out_free) begin
          state_next = tpig_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = tpig_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      tpig_pkg::BK_IDLE: begin
        if (pop_valid) begin
          for (int a = 0; a < MAX_RANK; a++) begin
            coord[a] <= pop_data[a*CW +: CW];
          end
          last_q <= pop_data[MAX_RANK*CW];
          src    <= '0;
          pad    <= 1'b0;
          ax     <= '0;
        end
      end
      tpig_pkg::BK_AXIS: begin
        s_val   <= axis_s;
        pad     <= pad | axis_pad;
        neg_q   <= neg;
        dvd     <= mag;
        rem     <= '0;
        cnt     <= '0;
        modulus <= modulus_axis;
        prod_lo <= mul_lo;
        prod_hi <= mul_hi;
      end
      tpig_pkg::BK_DIV: begin
        rem <= rem_step;
        dvd <= dvd << 1;
        cnt <= cnt + CNT_W'(1);
      end
      tpig_pkg::BK_REFL: begin
        s_val <= q1[DIM_BITS-1:0];
      end
      tpig_pkg::BK_ACC: begin
        src <= acc;
        ax  <= ax + AXW'(1);
      end
      tpig_pkg::BK_OUT: begin
        if (out_free) begin
          source_index <= pad ? '0 : src;
          is_padding   <= pad;
          last         <= last_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == tpig_pkg::BK_OUT && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

endmodule

FILE: hdl/tensor_pad_index_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tensor_pad_index_generator_top
// Walks a padded tensor output in row-major order and gives, per item, the
// source index, a padding flag and a last flag.
// ----------------------------------------------------------------------------
//  channel   handshake                   payload
//  item      item_valid / item_ready     restart
//  result    result_valid / result_ready source_index, is_padding, last
//  cfg       cfg_valid / cfg_ready       cfg_index, cfg_data (always ready)
//
//  The front takes one item per cycle into a two-entry queue while it has room.
//  The back takes an item only when done with the last and works axis by axis,
//  through the bit-serial remainder unit for each reflect axis of size above one.
//  Synchronous reset clears the coordinate, the queue, the back state and the
//  registers; a held result stalls the back, the queue absorbs items until full.
// ----------------------------------------------------------------------------
module tensor_pad_index_generator_top #(
  parameter int MAX_RANK = tpig_pkg::DEF_MAX_RANK,
  parameter int DIM_BITS = tpig_pkg::DEF_DIM_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  logic                           restart,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic [tpig_pkg::IDX_W-1:0]     source_index,
  output logic                           is_padding,
  output logic                           last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tpig_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tpig_pkg::CFG_W-1:0]     cfg_data
);

  localparam int CW     = DIM_BITS + 2;
  localparam int RCW    = $clog2(MAX_RANK + 1);
  localparam int QW     = MAX_RANK * CW + 1;
  localparam int WIDE_W = tpig_pkg::CFG_W + DIM_BITS;

  logic [tpig_pkg::MODE_W-1:0] pad_mode;
  logic [tpig_pkg::RANK_W-1:0] tensor_rank;
  logic [tpig_pkg::CFG_W-1:0]  input_sizes;
  logic [tpig_pkg::CFG_W-1:0]  leading_pads;
  logic [tpig_pkg::CFG_W-1:0]  trailing_pads;

  logic [WIDE_W-1:0]   sizes_wide;
  logic [WIDE_W-1:0]   leads_wide;
  logic [WIDE_W-1:0]   trails_wide;
  logic [DIM_BITS-1:0] sizes  [MAX_RANK];
  logic [DIM_BITS-1:0] leads  [MAX_RANK];
  logic [DIM_BITS-1:0] trails [MAX_RANK];
  logic [RCW-1:0]      active_rank;

  logic          push_valid;
  logic          push_ready;
  logic [QW-1:0] push_data;
  logic          pop_valid;
  logic          pop_ready;
  logic [QW-1:0] pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_mode      <= tpig_pkg::MODE_CONSTANT;
      tensor_rank   <= tpig_pkg::RANK_RESET;
      input_sizes   <= '0;
      leading_pads  <= '0;
      trailing_pads <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tpig_pkg::REG_PAD_MODE:      pad_mode      <= cfg_data[tpig_pkg::MODE_W-1:0];
        tpig_pkg::REG_TENSOR_RANK:   tensor_rank   <= cfg_data[tpig_pkg::RANK_W-1:0];
        tpig_pkg::REG_INPUT_SIZES:   input_sizes   <= cfg_data;
        tpig_pkg::REG_LEADING_PADS:  leading_pads  <= cfg_data;
        tpig_pkg::REG_TRAILING_PADS: trailing_pads <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // rank zero acts as one, anything above the maximum as the maximum
  always_comb begin
    if (tensor_rank == '0) begin
      active_rank = RCW'(1);
    end else if (int'(tensor_rank) > MAX_RANK) begin
      active_rank = RCW'(MAX_RANK);
    end else begin
      active_rank = RCW'(tensor_rank);
    end
  end

  // axis 0 sits in the top bits; slots past the register read as zero
  assign sizes_wide  = WIDE_W'(input_sizes);
  assign leads_wide  = WIDE_W'(leading_pads);
  assign trails_wide = WIDE_W'(trailing_pads);

  for (genvar a = 0; a < MAX_RANK; a++) begin : g_slot
    localparam int SHIFT = (MAX_RANK - 1 - a) * DIM_BITS;
    if (SHIFT < tpig_pkg::CFG_W) begin : g_in
      assign sizes[a]  = sizes_wide[SHIFT +: DIM_BITS];
      assign leads[a]  = leads_wide[SHIFT +: DIM_BITS];
      assign trails[a] = trails_wide[SHIFT +: DIM_BITS];
    end else begin : g_out
      assign sizes[a]  = '0;
      assign leads[a]  = '0;
      assign trails[a] = '0;
    end
  end

  tpig_front #(
    .MAX_RANK (MAX_RANK),
    .DIM_BITS (DIM_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .restart     (restart),
    .active_rank (active_rank),
    .sizes       (sizes),
    .leads       (leads),
    .trails      (trails),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  tpig_queue #(
    .W (QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  tpig_back #(
    .MAX_RANK (MAX_RANK),
    .DIM_BITS (DIM_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .mode         (pad_mode),
    .active_rank  (active_rank),
    .sizes        (sizes),
    .leads        (leads),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .source_index (source_index),
    .is_padding   (is_padding),
    .last         (last)
  );

endmodule
